### hw/rtl/ghsm_pkg.sv
// Shared types and codes for the generational handle slot map.
`timescale 1ns / 1ps
package ghsm_pkg;
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_DEL = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_GET = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_ID_FULL = 3'd2;
    localparam logic [2:0] ST_TYPE_FULL = 3'd3;
    localparam logic [2:0] ST_QUEUE_FULL = 3'd4;

    // One accepted command as it travels from the front end to the back end.
    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  entity_type;
        logic [9:0]  handle_id;
        logic [15:0] handle_generation;
        logic [1:0]  handle_type;
        logic [31:0] payload;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  out_id;
        logic [15:0] out_generation;
        logic [31:0] out_payload;
        logic [7:0]  out_dense_index;
        logic [10:0] removed_count;
    } rsp_t;
endpackage

### hw/rtl/ghsm_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps
module ghsm_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  ghsm_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output ghsm_pkg::cmd_t out_cmd
);
    import ghsm_pkg::*;

    cmd_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd   = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= in_cmd;
        end
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop) rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

### hw/rtl/ghsm_engine.sv
// Back end: slot, dense and queue memories plus the command sequencer.
`timescale 1ns / 1ps
module ghsm_engine (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  ghsm_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output ghsm_pkg::rsp_t rsp
);
    import ghsm_pkg::*;

    localparam int IDS = 1024;
    localparam int CAP = 256;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_EXEC  = 7'b0000100,
        S_FQRD  = 7'b0001000,
        S_FSLOT = 7'b0010000,
        S_FMOVE = 7'b0100000,
        S_RESP  = 7'b1000000
    } state_t;

    // Slot entry packs type, generation, dense index and deleted flag.
    typedef struct packed {
        logic        deleted;
        logic [1:0]  stype;
        logic [15:0] gen;
        logic [7:0]  didx;
    } slot_t;

    slot_t       slot_mem [IDS];
    logic [9:0]  free_mem [IDS];
    logic [9:0]  owner_mem [IDS];
    logic [31:0] data_mem [IDS];
    logic [27:0] queue_mem [IDS];

    state_t      state_reg;
    cmd_t        cmd_reg;
    rsp_t        rsp_reg;
    logic [10:0] ids_used_reg, free_count_reg, pend_count_reg;
    logic [8:0]  type_count_reg [4];
    logic [10:0] fidx_reg, removed_reg;

    // Registered read data.
    slot_t       slot_rd_reg;
    logic [9:0]  free_rd_reg, owner_rd_reg;
    logic [31:0] data_rd_reg;
    logic [27:0] queue_rd_reg;

    // Flush working registers.
    logic [9:0]  eid_reg;
    logic [15:0] egen_reg;
    logic [1:0]  etype_reg;
    logic [7:0]  last_reg;

    logic        slot_we;
    logic [9:0]  slot_wa, slot_ra;
    slot_t       slot_wd;
    logic        slot_we2;
    logic [9:0]  slot_wa2;
    logic [7:0]  slot_wd2;
    logic [9:0]  owner_ra, data_ra;
    logic [9:0]  free_ra;
    logic [9:0]  queue_ra;

    logic        hv_ok;
    logic [8:0]  tc_h;
    logic        has_free;

    logic [8:0]  tc_e;
    logic [7:0]  hole;
    logic [7:0]  last_idx;
    logic        f_ok;

    logic        add_ok, del_ok;
    rsp_t        exec_rsp;
    state_t      exec_state;

    logic        fresh_reg;

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_RESP);
    assign rsp       = rsp_reg;

    assign has_free = free_count_reg != 11'd0;

    assign tc_h  = type_count_reg[cmd_reg.handle_type];
    assign hv_ok = ({1'b0, cmd_reg.handle_id} < ids_used_reg) && !slot_rd_reg.deleted
                   && slot_rd_reg.gen == cmd_reg.handle_generation
                   && slot_rd_reg.stype == cmd_reg.handle_type
                   && {1'b0, slot_rd_reg.didx} < tc_h;

    assign tc_e = type_count_reg[etype_reg];
    assign f_ok = ({1'b0, eid_reg} < ids_used_reg) && !slot_rd_reg.deleted
                  && slot_rd_reg.gen == egen_reg && slot_rd_reg.stype == etype_reg
                  && {1'b0, slot_rd_reg.didx} < tc_e;
    assign hole = slot_rd_reg.didx;
    assign last_idx = 8'(tc_e - 9'd1);

    // Read addresses for the next cycle.
    always_comb begin
        slot_ra  = cmd_reg.handle_id;
        owner_ra = 10'd0;
        data_ra  = {cmd_reg.handle_type, slot_rd_reg.didx};
        free_ra  = free_count_reg[9:0] - 10'd1;
        queue_ra = fidx_reg[9:0];
        case (state_reg)
            S_RD:    queue_ra = 10'd0;
            S_EXEC: begin
                // An add fetches the slot of the id it is about to take.
                if (cmd_reg.op == OP_ADD) slot_ra = has_free ? free_rd_reg : ids_used_reg[9:0];
            end
            S_FQRD:  slot_ra = queue_rd_reg[27:18];
            S_FSLOT: begin
                slot_ra  = eid_reg;
                owner_ra = {etype_reg, last_idx};
                data_ra  = {etype_reg, last_idx};
                queue_ra = fidx_reg[9:0] + 10'd1;
            end
            S_FMOVE: queue_ra = fidx_reg[9:0] + 10'd1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        slot_rd_reg  <= slot_mem[slot_ra];
        free_rd_reg  <= free_mem[free_ra];
        owner_rd_reg <= owner_mem[owner_ra];
        data_rd_reg  <= data_mem[data_ra];
        queue_rd_reg <= queue_mem[queue_ra];
    end

    // Outcome of the execute step for add, delete and get.
    always_comb begin
        add_ok     = 1'b0;
        del_ok     = 1'b0;
        exec_rsp   = '0;
        exec_state = S_RESP;
        case (cmd_reg.op)
            OP_ADD: begin
                if (free_count_reg == 11'd0 && ids_used_reg >= 11'(IDS)) begin
                    exec_rsp.status = ST_ID_FULL;
                end else if (type_count_reg[cmd_reg.entity_type] >= 9'(CAP)) begin
                    exec_rsp.status = ST_TYPE_FULL;
                end else begin
                    add_ok     = 1'b1;
                    exec_state = S_FMOVE;
                end
            end
            OP_DEL: begin
                if (!hv_ok) exec_rsp.status = ST_INVALID;
                else if (pend_count_reg >= 11'(IDS)) exec_rsp.status = ST_QUEUE_FULL;
                else del_ok = 1'b1;
            end
            default: begin
                if (!hv_ok) begin
                    exec_rsp.status = ST_INVALID;
                end else begin
                    exec_rsp.out_dense_index = slot_rd_reg.didx;
                    exec_state = S_FSLOT;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            ids_used_reg   <= '0;
            free_count_reg <= '0;
            pend_count_reg <= '0;
            for (int i = 0; i < 4; i++) type_count_reg[i] <= '0;
        end else begin
            case (state_reg)
                S_IDLE: if (cmd_valid) begin
                    cmd_reg   <= cmd;
                    state_reg <= S_RD;
                end
                S_RD: state_reg <= (cmd_reg.op == OP_FLUSH) ? S_FQRD : S_EXEC;
                S_EXEC: begin
                    rsp_reg   <= exec_rsp;
                    state_reg <= exec_state;
                    if (add_ok) begin
                        if (has_free) begin
                            free_count_reg <= free_count_reg - 11'd1;
                            eid_reg <= free_rd_reg;
                        end else begin
                            ids_used_reg <= ids_used_reg + 11'd1;
                            eid_reg <= ids_used_reg[9:0];
                        end
                        type_count_reg[cmd_reg.entity_type] <=
                            type_count_reg[cmd_reg.entity_type] + 9'd1;
                    end
                    if (del_ok) pend_count_reg <= pend_count_reg + 11'd1;
                end
                S_FQRD: begin
                    // Queue word for fidx_reg is in queue_rd_reg; slot read issued.
                    if (fidx_reg >= pend_count_reg) begin
                        rsp_reg <= '{status: ST_OK, out_id: 10'd0, out_generation: 16'd0,
                                     out_payload: 32'd0, out_dense_index: 8'd0,
                                     removed_count: removed_reg};
                        pend_count_reg <= '0;
                        state_reg <= S_RESP;
                    end else begin
                        eid_reg   <= queue_rd_reg[27:18];
                        egen_reg  <= queue_rd_reg[17:2];
                        etype_reg <= queue_rd_reg[1:0];
                        state_reg <= S_FSLOT;
                    end
                end
                S_FSLOT: begin
                    if (cmd_reg.op == OP_GET) begin
                        // Data read at the dense slot is now registered.
                        rsp_reg.out_payload <= data_rd_reg;
                        state_reg <= S_RESP;
                    end else if (f_ok) begin
                        last_reg  <= last_idx;
                        state_reg <= S_FMOVE;
                    end else begin
                        fidx_reg  <= fidx_reg + 11'd1;
                        state_reg <= S_FQRD;
                    end
                end
                S_FMOVE: begin
                    if (cmd_reg.op == OP_ADD) begin
                        rsp_reg.out_id <= eid_reg;
                        rsp_reg.out_generation <= fresh_reg ? 16'd1 : slot_rd_reg.gen;
                        rsp_reg.out_dense_index <= 8'(type_count_reg[cmd_reg.entity_type] - 9'd1);
                        state_reg <= S_RESP;
                    end else begin
                        type_count_reg[etype_reg] <= tc_e - 9'd1;
                        if (free_count_reg < 11'(IDS)) free_count_reg <= free_count_reg + 11'd1;
                        removed_reg <= removed_reg + 11'd1;
                        fidx_reg    <= fidx_reg + 11'd1;
                        state_reg   <= S_FQRD;
                    end
                end
                S_RESP: if (rsp_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
            if (state_reg == S_RD) begin
                fidx_reg    <= '0;
                removed_reg <= '0;
            end
        end
    end

    // The slot entry of a reused id must be read before the add writes it.
    always_ff @(posedge aclk) begin
        if (state_reg == S_EXEC) fresh_reg <= !has_free;
    end

    // Write ports.
    logic        free_we, owner_we, data_we, queue_we;
    logic [9:0]  free_wa, owner_wa, own_wd;
    logic [31:0] data_wd;
    logic [8:0]  nidx;
    assign nidx = type_count_reg[cmd_reg.entity_type];
    always_comb begin
        slot_we = 1'b0; slot_wa = eid_reg; slot_wd = slot_rd_reg;
        slot_we2 = 1'b0; slot_wa2 = owner_rd_reg; slot_wd2 = last_reg;
        free_we = 1'b0; free_wa = free_count_reg[9:0];
        owner_we = 1'b0; owner_wa = '0; own_wd = '0;
        data_we = 1'b0; data_wd = '0;
        queue_we = (state_reg == S_EXEC) && del_ok;
        if (state_reg == S_FMOVE && cmd_reg.op == OP_ADD) begin
            // Slot entry for a new id: fresh ids start at generation one.
            slot_we = 1'b1;
            slot_wd.deleted = 1'b0;
            slot_wd.stype = cmd_reg.entity_type;
            slot_wd.didx = 8'(nidx - 9'd1);
            if (fresh_reg) slot_wd.gen = 16'd1;
            owner_we = 1'b1;
            owner_wa = {cmd_reg.entity_type, 8'(nidx - 9'd1)};
            own_wd = eid_reg;
            data_we = 1'b1;
            data_wd = cmd_reg.payload;
        end else if (state_reg == S_FMOVE && cmd_reg.op == OP_FLUSH) begin
            slot_we = 1'b1;
            slot_wd.gen = slot_rd_reg.gen + 16'd1;
            slot_wd.deleted = 1'b1;
            free_we = free_count_reg < 11'(IDS);
            if (hole != last_reg) begin
                owner_we = 1'b1;
                owner_wa = {etype_reg, hole};
                own_wd = owner_rd_reg;
                data_we = 1'b1;
                data_wd = data_rd_reg;
                slot_we2 = 1'b1;
                slot_wd2 = hole;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_we2) slot_mem[slot_wa2].didx <= slot_wd2;
        if (slot_we) slot_mem[slot_wa] <= slot_wd;
        if (free_we) free_mem[free_wa] <= eid_reg;
        if (owner_we) owner_mem[owner_wa] <= own_wd;
        if (data_we) data_mem[owner_wa] <= data_wd;
        if (queue_we) queue_mem[pend_count_reg[9:0]] <=
            {cmd_reg.handle_id, cmd_reg.handle_generation, cmd_reg.handle_type};
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reg))
        else $error("response changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        free_count_reg <= 11'(IDS))
        else $error("free stack overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");
endmodule

### hw/rtl/ghsm_front.sv
// Front end: input register that holds each command beat until the queue takes it.
`timescale 1ns / 1ps
module ghsm_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ghsm_pkg::cmd_t s_cmd,
    output logic           q_valid,
    input  logic           q_ready,
    output ghsm_pkg::cmd_t q_cmd
);
    import ghsm_pkg::*;

    logic  full_reg;
    cmd_t  cmd_reg;

    assign s_ready = !full_reg || q_ready;
    assign q_valid = full_reg;
    assign q_cmd   = cmd_reg;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) cmd_reg <= s_cmd;
        if (!aresetn) full_reg <= 1'b0;
        else if (s_ready) full_reg <= s_valid;
    end
endmodule

### hw/rtl/generational_handle_slot_map_top.sv
// Top level of the generational handle slot map.
//   channel | ports    | direction | contents
//   command | s_*      | in        | op, types, handle, payload
//   result  | m_*      | out       | status, handle, payload, index, count
// With no stalls, a command beat passes through the front register and the
// two-entry queue, then the sequencer steps through idle, read and execute to
// the result, with one more step for an add or a good get. A flush steps through
// its queue entries instead, with a queue read and a slot step per skipped entry
// and a move step as well per removed entity. Reset is synchronous and active
// low; all counters start at zero and memories need no clearing. A stalled
// result holds the sequencer, while the front keeps taking beats until the queue
// and the front register fill.
`timescale 1ns / 1ps
module generational_handle_slot_map_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [1:0]  s_entity_type,
    input  logic [9:0]  s_handle_id,
    input  logic [15:0] s_handle_generation,
    input  logic [1:0]  s_handle_type,
    input  logic [31:0] s_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [9:0]  m_out_id,
    output logic [15:0] m_out_generation,
    output logic [31:0] m_out_payload,
    output logic [7:0]  m_out_dense_index,
    output logic [10:0] m_removed_count
);
    import ghsm_pkg::*;

    cmd_t in_cmd, f_cmd, e_cmd;
    rsp_t rsp;
    logic f_valid, f_ready, e_valid, e_ready;

    assign in_cmd = '{op: s_op, entity_type: s_entity_type, handle_id: s_handle_id,
                      handle_generation: s_handle_generation,
                      handle_type: s_handle_type, payload: s_payload};

    ghsm_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_cmd(in_cmd), .q_valid(f_valid), .q_ready(f_ready), .q_cmd(f_cmd)
    );

    ghsm_cmd_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn), .in_valid(f_valid), .in_ready(f_ready),
        .in_cmd(f_cmd), .out_valid(e_valid), .out_ready(e_ready), .out_cmd(e_cmd)
    );

    ghsm_engine u_engine (
        .aclk(aclk), .aresetn(aresetn), .cmd_valid(e_valid), .cmd_ready(e_ready),
        .cmd(e_cmd), .rsp_valid(m_valid), .rsp_ready(m_ready), .rsp(rsp)
    );

    assign m_status          = rsp.status;
    assign m_out_id          = rsp.out_id;
    assign m_out_generation  = rsp.out_generation;
    assign m_out_payload     = rsp.out_payload;
    assign m_out_dense_index = rsp.out_dense_index;
    assign m_removed_count   = rsp.removed_count;
endmodule

### bench/tb_generational_handle_slot_map_top.sv
// Self-checking testbench for the generational handle slot map top level.
`timescale 1ns / 1ps
module tb_generational_handle_slot_map_top;
    import ghsm_pkg::*;

    localparam int MAX_IDS = 1024;
    localparam int NUM_TYPES = 4;
    localparam int TYPE_CAP = 256;
    localparam int CYCLE_LIMIT = 1500000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_op;
    logic [1:0]  s_entity_type;
    logic [9:0]  s_handle_id;
    logic [15:0] s_handle_generation;
    logic [1:0]  s_handle_type;
    logic [31:0] s_payload;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [9:0]  m_out_id;
    logic [15:0] m_out_generation;
    logic [31:0] m_out_payload;
    logic [7:0]  m_out_dense_index;
    logic [10:0] m_removed_count;

    generational_handle_slot_map_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_entity_type(s_entity_type), .s_handle_id(s_handle_id),
        .s_handle_generation(s_handle_generation), .s_handle_type(s_handle_type),
        .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_out_id(m_out_id), .m_out_generation(m_out_generation),
        .m_out_payload(m_out_payload), .m_out_dense_index(m_out_dense_index),
        .m_removed_count(m_removed_count)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Shadow copy of the slot map state, updated once per accepted command beat.
    logic [1:0]  shd_type [MAX_IDS];
    logic [15:0] shd_gen [MAX_IDS];
    int          shd_idx [MAX_IDS];
    bit          shd_deleted [MAX_IDS];
    int          shd_ids_used;
    int          shd_free [MAX_IDS];
    int          shd_free_cnt;
    int          shd_owner [NUM_TYPES][TYPE_CAP];
    logic [31:0] shd_data [NUM_TYPES][TYPE_CAP];
    int          shd_type_cnt [NUM_TYPES];
    int          shd_del_id [MAX_IDS];
    logic [15:0] shd_del_gen [MAX_IDS];
    logic [1:0]  shd_del_type [MAX_IDS];
    int          shd_del_cnt;

    // Results the block still owes us, oldest first.
    rsp_t slot_rsp_q[$];
    int   mismatches;
    bit   calm;
    int   cycles;

    // A directed row carries its command and, where set, a hand-written result.
    typedef struct {
        cmd_t cmd;
        bit   typed;
        rsp_t rsp;
    } dir_row_t;
    dir_row_t dir_rows[$];

    function automatic bit handle_live(int id, logic [15:0] gen, logic [1:0] ty);
        if (id >= shd_ids_used) return 1'b0;
        if (shd_deleted[id]) return 1'b0;
        if (shd_gen[id] != gen || shd_type[id] != ty) return 1'b0;
        return shd_idx[id] < shd_type_cnt[ty];
    endfunction

    // Applies one command to the shadow state and returns the result it earns.
    function automatic rsp_t slot_map_apply(cmd_t c);
        rsp_t r;
        int id, idx, ty, last, mover, removed;
        r = '0;
        case (c.op)
            OP_ADD: begin
                ty = c.entity_type;
                if (shd_free_cnt == 0 && shd_ids_used >= MAX_IDS) begin
                    r.status = ST_ID_FULL;
                end else if (shd_type_cnt[ty] >= TYPE_CAP) begin
                    r.status = ST_TYPE_FULL;
                end else begin
                    if (shd_free_cnt > 0) begin
                        shd_free_cnt--;
                        id = shd_free[shd_free_cnt];
                    end else begin
                        id = shd_ids_used;
                        shd_ids_used++;
                        shd_gen[id] = 16'd1;
                    end
                    idx = shd_type_cnt[ty];
                    shd_type_cnt[ty]++;
                    shd_deleted[id] = 1'b0;
                    shd_type[id] = c.entity_type;
                    shd_idx[id] = idx;
                    shd_owner[ty][idx] = id;
                    shd_data[ty][idx] = c.payload;
                    r.out_id = id[9:0];
                    r.out_generation = shd_gen[id];
                    r.out_dense_index = idx[7:0];
                end
            end
            OP_DEL: begin
                if (!handle_live(c.handle_id, c.handle_generation, c.handle_type)) begin
                    r.status = ST_INVALID;
                end else if (shd_del_cnt >= MAX_IDS) begin
                    r.status = ST_QUEUE_FULL;
                end else begin
                    shd_del_id[shd_del_cnt] = c.handle_id;
                    shd_del_gen[shd_del_cnt] = c.handle_generation;
                    shd_del_type[shd_del_cnt] = c.handle_type;
                    shd_del_cnt++;
                end
            end
            OP_FLUSH: begin
                removed = 0;
                for (int i = 0; i < shd_del_cnt; i++) begin
                    // Entries made stale by an earlier removal are skipped.
                    if (handle_live(shd_del_id[i], shd_del_gen[i], shd_del_type[i])) begin
                        id = shd_del_id[i];
                        ty = shd_type[id];
                        idx = shd_idx[id];
                        last = shd_type_cnt[ty] - 1;
                        if (idx != last) begin
                            mover = shd_owner[ty][last];
                            shd_owner[ty][idx] = mover;
                            shd_data[ty][idx] = shd_data[ty][last];
                            shd_idx[mover] = idx;
                        end
                        shd_type_cnt[ty] = last;
                        shd_gen[id] = shd_gen[id] + 16'd1;
                        shd_deleted[id] = 1'b1;
                        shd_free[shd_free_cnt] = id;
                        shd_free_cnt++;
                        removed++;
                    end
                end
                shd_del_cnt = 0;
                r.removed_count = removed[10:0];
            end
            default: begin
                if (!handle_live(c.handle_id, c.handle_generation, c.handle_type)) begin
                    r.status = ST_INVALID;
                end else begin
                    idx = shd_idx[c.handle_id];
                    r.out_payload = shd_data[c.handle_type][idx];
                    r.out_dense_index = idx[7:0];
                end
            end
        endcase
        return r;
    endfunction

    function automatic cmd_t mk_cmd(logic [1:0] op, logic [1:0] et, logic [9:0] id,
                                    logic [15:0] gen, logic [1:0] ht, logic [31:0] pay);
        cmd_t c;
        c.op = op;
        c.entity_type = et;
        c.handle_id = id;
        c.handle_generation = gen;
        c.handle_type = ht;
        c.payload = pay;
        return c;
    endfunction

    function automatic rsp_t mk_rsp(logic [2:0] st, logic [9:0] id, logic [15:0] gen,
                                    logic [31:0] pay, logic [7:0] idx, logic [10:0] rc);
        rsp_t r;
        r.status = st;
        r.out_id = id;
        r.out_generation = gen;
        r.out_payload = pay;
        r.out_dense_index = idx;
        r.removed_count = rc;
        return r;
    endfunction

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_cmd(cmd_t c, bit typed, rsp_t typed_rsp);
        int gap;
        rsp_t r;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= c.op;
        s_entity_type <= c.entity_type;
        s_handle_id <= c.handle_id;
        s_handle_generation <= c.handle_generation;
        s_handle_type <= c.handle_type;
        s_payload <= c.payload;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = slot_map_apply(c);
        slot_rsp_q.push_back(typed ? typed_rsp : r);
        @(negedge aclk);
    endtask

    task automatic send_pred(cmd_t c);
        send_cmd(c, 1'b0, '0);
    endtask

    // Holds the command side until the block has answered everything.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (slot_rsp_q.size() != 0) @(negedge aclk);
    endtask

    // A handle that mostly names a slot in use, sometimes with a stale stamp.
    function automatic cmd_t handle_cmd(logic [1:0] op);
        int id;
        logic [15:0] gen;
        logic [1:0] ht;
        id = (shd_ids_used > 0) ? $urandom_range(0, shd_ids_used - 1) : 0;
        gen = shd_gen[id];
        ht = shd_type[id];
        if ($urandom_range(0, 9) == 0) gen = gen ^ 16'($urandom_range(1, 65535));
        if ($urandom_range(0, 19) == 0) ht = ht ^ 2'($urandom_range(1, 3));
        return mk_cmd(op, 2'($urandom), 10'(id), gen, ht, $urandom);
    endfunction

    task automatic note_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
        if (mismatches < 10)
            $display("mismatch on %s: expected %0h, got %0h", what, exp_v, act_v);
        mismatches++;
    endtask

    // Result side: every accepted beat is checked against the oldest expectation.
    always @(posedge aclk) begin
        rsp_t e;
        if (aresetn && m_valid && m_ready) begin
            if (slot_rsp_q.size() == 0) begin
                note_mismatch("unexpected result beat", 32'd0, 32'd1);
            end else begin
                e = slot_rsp_q.pop_front();
                if (m_status != e.status) note_mismatch("status", e.status, m_status);
                if (m_out_id != e.out_id) note_mismatch("out_id", e.out_id, m_out_id);
                if (m_out_generation != e.out_generation)
                    note_mismatch("out_generation", e.out_generation, m_out_generation);
                if (m_out_payload != e.out_payload)
                    note_mismatch("out_payload", e.out_payload, m_out_payload);
                if (m_out_dense_index != e.out_dense_index)
                    note_mismatch("out_dense_index", e.out_dense_index, m_out_dense_index);
                if (m_removed_count != e.removed_count)
                    note_mismatch("removed_count", e.removed_count, m_removed_count);
            end
        end
    end

    // Watchdog: a hung block ends the run here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_generational_handle_slot_map_top failed");
            $finish;
        end
    end

    // Result side backpressure: a random stall before each beat, none when calm.
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin
        cmd_t c;
        int pick;
        mismatches = 0;
        calm = 1'b0;
        shd_ids_used = 0;
        shd_free_cnt = 0;
        shd_del_cnt = 0;
        for (int t = 0; t < NUM_TYPES; t++) shd_type_cnt[t] = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op = OP_ADD;
        s_entity_type = '0;
        s_handle_id = '0;
        s_handle_generation = '0;
        s_handle_type = '0;
        s_payload = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part. Right after reset nothing is live, so handles fail.
        dir_rows.push_back('{mk_cmd(OP_GET, 2'd0, 10'd0, 16'd0, 2'd0, 32'd0), 1'b1,
                             mk_rsp(ST_INVALID, 10'd0, 16'd0, 32'd0, 8'd0, 11'd0)});
        dir_rows.push_back('{mk_cmd(OP_DEL, 2'd0, 10'h3FF, 16'hFFFF, 2'd3, 32'd0), 1'b1,
                             mk_rsp(ST_INVALID, 10'd0, 16'd0, 32'd0, 8'd0, 11'd0)});
        dir_rows.push_back('{mk_cmd(OP_FLUSH, 2'd0, 10'd0, 16'd0, 2'd0, 32'd0), 1'b1,
                             mk_rsp(ST_OK, 10'd0, 16'd0, 32'd0, 8'd0, 11'd0)});
        // Fresh ids start at generation one.
        dir_rows.push_back('{mk_cmd(OP_ADD, 2'd0, 10'd0, 16'd0, 2'd0, 32'hFFFF_FFFF), 1'b1,
                             mk_rsp(ST_OK, 10'd0, 16'd1, 32'd0, 8'd0, 11'd0)});
        dir_rows.push_back('{mk_cmd(OP_ADD, 2'd3, 10'h3FF, 16'hFFFF, 2'd3, 32'h0), 1'b1,
                             mk_rsp(ST_OK, 10'd1, 16'd1, 32'd0, 8'd0, 11'd0)});
        dir_rows.push_back('{mk_cmd(OP_GET, 2'd0, 10'd0, 16'd1, 2'd0, 32'd0), 1'b1,
                             mk_rsp(ST_OK, 10'd0, 16'd0, 32'hFFFF_FFFF, 8'd0, 11'd0)});
        dir_rows.push_back('{mk_cmd(OP_GET, 2'd0, 10'd0, 16'd2, 2'd0, 32'd0), 1'b1,
                             mk_rsp(ST_INVALID, 10'd0, 16'd0, 32'd0, 8'd0, 11'd0)});
        dir_rows.push_back('{mk_cmd(OP_GET, 2'd0, 10'd0, 16'd1, 2'd1, 32'd0), 1'b1,
                             mk_rsp(ST_INVALID, 10'd0, 16'd0, 32'd0, 8'd0, 11'd0)});
        dir_rows.push_back('{mk_cmd(OP_GET, 2'd0, 10'h3FF, 16'd1, 2'd0, 32'd0), 1'b1,
                             mk_rsp(ST_INVALID, 10'd0, 16'd0, 32'd0, 8'd0, 11'd0)});
        // A handle queued twice: the second entry is stale at flush time.
        dir_rows.push_back('{mk_cmd(OP_DEL, 2'd0, 10'd0, 16'd1, 2'd0, 32'd0), 1'b1,
                             mk_rsp(ST_OK, 10'd0, 16'd0, 32'd0, 8'd0, 11'd0)});
        dir_rows.push_back('{mk_cmd(OP_DEL, 2'd0, 10'd0, 16'd1, 2'd0, 32'd0), 1'b1,
                             mk_rsp(ST_OK, 10'd0, 16'd0, 32'd0, 8'd0, 11'd0)});
        dir_rows.push_back('{mk_cmd(OP_FLUSH, 2'd0, 10'd0, 16'd0, 2'd0, 32'd0), 1'b1,
                             mk_rsp(ST_OK, 10'd0, 16'd0, 32'd0, 8'd0, 11'd1)});
        dir_rows.push_back('{mk_cmd(OP_GET, 2'd0, 10'd0, 16'd1, 2'd0, 32'd0), 1'b1,
                             mk_rsp(ST_INVALID, 10'd0, 16'd0, 32'd0, 8'd0, 11'd0)});
        // The recycled id keeps its bumped generation.
        dir_rows.push_back('{mk_cmd(OP_ADD, 2'd2, 10'd0, 16'd0, 2'd0, 32'h1234_5678), 1'b1,
                             mk_rsp(ST_OK, 10'd0, 16'd2, 32'd0, 8'd0, 11'd0)});
        dir_rows.push_back('{mk_cmd(OP_GET, 2'd0, 10'd0, 16'd2, 2'd2, 32'd0), 1'b0, '0});
        // Swap-remove: deleting the first of three moves the last into its hole.
        dir_rows.push_back('{mk_cmd(OP_ADD, 2'd1, 10'd0, 16'd0, 2'd0, 32'hA5A5_0001), 1'b0, '0});
        dir_rows.push_back('{mk_cmd(OP_ADD, 2'd1, 10'd0, 16'd0, 2'd0, 32'h5A5A_0002), 1'b0, '0});
        dir_rows.push_back('{mk_cmd(OP_ADD, 2'd1, 10'd0, 16'd0, 2'd0, 32'hC3C3_0003), 1'b0, '0});
        dir_rows.push_back('{mk_cmd(OP_DEL, 2'd0, 10'd2, 16'd1, 2'd1, 32'd0), 1'b0, '0});
        dir_rows.push_back('{mk_cmd(OP_FLUSH, 2'd0, 10'd0, 16'd0, 2'd0, 32'd0), 1'b0, '0});
        dir_rows.push_back('{mk_cmd(OP_GET, 2'd0, 10'd4, 16'd1, 2'd1, 32'd0), 1'b0, '0});
        dir_rows.push_back('{mk_cmd(OP_GET, 2'd0, 10'd3, 16'd1, 2'd1, 32'd0), 1'b0, '0});
        dir_rows.push_back('{mk_cmd(OP_GET, 2'd0, 10'd1, 16'd1, 2'd3, 32'd0), 1'b0, '0});
        foreach (dir_rows[i]) send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].rsp);

        // Hold-off: nothing more goes in until every result is back.
        drain_results();

        // Random part: adds, deletes, flushes and gets, with handles mostly live, and some noise.
        for (int n = 0; n < 150; n++) begin
            if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 35)
                c = mk_cmd(OP_ADD, 2'($urandom), 10'($urandom), 16'($urandom),
                           2'($urandom), $urandom);
            else if (pick < 60) c = handle_cmd(OP_DEL);
            else if (pick < 68) c = mk_cmd(OP_FLUSH, 2'($urandom), 10'($urandom),
                                           16'($urandom), 2'($urandom), $urandom);
            else if (pick < 90) c = handle_cmd(OP_GET);
            else c = mk_cmd(2'($urandom), 2'($urandom), 10'($urandom), 16'($urandom),
                            2'($urandom), $urandom);
            send_pred(c);
            if (n == 75) drain_results();
        end

        // Capacity: fill one type store until it refuses an add.
        calm = 1'b1;
        while (shd_type_cnt[0] < TYPE_CAP)
            send_pred(mk_cmd(OP_ADD, 2'd0, 10'd0, 16'd0, 2'd0, $urandom));
        send_pred(mk_cmd(OP_ADD, 2'd0, 10'd0, 16'd0, 2'd0, $urandom));
        send_pred(mk_cmd(OP_DEL, 2'd0, 10'd0, shd_gen[0], shd_type[0], 32'd0));
        send_pred(mk_cmd(OP_FLUSH, 2'd0, 10'd0, 16'd0, 2'd0, 32'd0));
        send_pred(mk_cmd(OP_ADD, 2'd1, 10'd0, 16'd0, 2'd0, $urandom));
        send_pred(mk_cmd(OP_ADD, 2'd2, 10'd0, 16'd0, 2'd0, $urandom));
        calm = 1'b0;
        for (int n = 0; n < 20; n++) begin
            c = ($urandom_range(0, 1) == 0) ? handle_cmd(OP_GET)
                : mk_cmd(OP_ADD, 2'($urandom), 10'd0, 16'd0, 2'd0, $urandom);
            send_pred(c);
        end

        s_valid <= 1'b0;
        while (slot_rsp_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (mismatches == 0 && slot_rsp_q.size() == 0) begin
            $display("tb_generational_handle_slot_map_top passed");
        end else begin
            $display("tb_generational_handle_slot_map_top failed");
        end
        $finish;
    end
endmodule
